FILE: rtl/swb_pkg.sv
// Shared types and constants of the similarity warp bilinear core.
package swb_pkg;

   localparam int COORD_W   = 12;  // source coordinate bits, covers up to 4096 pixels
   localparam int MID_DEPTH = 4;
   localparam int MID_CW    = 3;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_CW    = 3;

   localparam logic [2:0] CSR_SCALE_COS  = 3'd0;
   localparam logic [2:0] CSR_SCALE_SIN  = 3'd1;
   localparam logic [2:0] CSR_SHIFT_COL  = 3'd2;
   localparam logic [2:0] CSR_SHIFT_ROW  = 3'd3;
   localparam logic [2:0] CSR_SRC_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_SRC_HEIGHT = 3'd5;

   typedef struct packed {
      logic signed [31:0] scale_cos;
      logic signed [31:0] scale_sin;
      logic signed [31:0] shift_col;
      logic signed [31:0] shift_row;
      logic [9:0]         src_width;
      logic [9:0]         src_height;
   } swb_cfg_type;

   // One classified item between the front and the back.
   typedef struct packed {
      logic               is_req;
      logic               wr_ok;
      logic               in_bounds;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [23:0]        pix;
      logic [16:0]        w00;
      logic [16:0]        w01;
      logic [16:0]        w10;
      logic [16:0]        w11;
      logic [6:0]         dst_col;
      logic [6:0]         dst_row;
   } swb_item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       in_bounds;
      logic [6:0] col;
      logic [6:0] row;
   } swb_result_type;

endpackage

FILE: rtl/swb_ram.sv
// Generic simple dual-port RAM with registered read.
module swb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/swb_fifo.sv
// Small register FIFO with occupancy count.
module swb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push = push && (count_ff != CW'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

FILE: rtl/swb_front.sv
// Front: accepts items, maps request coordinates and classifies them.
module swb_front #(
   parameter int MAX_SRC_WIDTH  = 512,
   parameter int MAX_SRC_HEIGHT = 512
) (
   input  logic                      clock,
   input  logic                      reset,
   input  swb_pkg::swb_cfg_type      cfg,
   input  logic                      in_push,
   output logic                      in_full,
   input  logic                      in_type,
   input  logic [8:0]                in_src_col,
   input  logic [8:0]                in_src_row,
   input  logic [23:0]               in_pix,
   input  logic [6:0]                in_dst_col,
   input  logic [6:0]                in_dst_row,
   input  logic [swb_pkg::MID_CW-1:0] mid_count,
   output logic                      mid_push,
   output swb_pkg::swb_item_type     mid_item
);

   localparam logic [12:0] MAX_W = 13'(MAX_SRC_WIDTH);
   localparam logic [12:0] MAX_H = 13'(MAX_SRC_HEIGHT);

   logic accept;

   // stage 1: products
   logic               f1_v_ff;
   logic               f1_req_ff;
   logic               f1_wr_ok_ff;
   logic [8:0]         f1_col_ff, f1_row_ff;
   logic [23:0]        f1_pix_ff;
   logic [6:0]         f1_dc_ff, f1_dr_ff;
   logic signed [39:0] f1_ac_ff, f1_br_ff, f1_bc_ff, f1_ar_ff;

   // stage 2: sums, floor, inside test
   logic               f2_v_ff;
   logic               f2_req_ff, f2_wr_ok_ff, f2_inside_ff;
   logic [swb_pkg::COORD_W-1:0] f2_col_ff, f2_row_ff;
   logic [7:0]         f2_fc_ff, f2_fr_ff;
   logic [23:0]        f2_pix_ff;
   logic [6:0]         f2_dc_ff, f2_dr_ff;

   logic signed [41:0] sc, sr;
   logic [12:0]        w_eff, h_eff;
   logic               inside_in;
   logic [swb_pkg::COORD_W-1:0] col_in, row_in;
   logic [8:0]         wc, wr;
   logic [17:0]        p00, p01, p10, p11;

   // entries in flight count against the queue so it never overflows
   assign in_full = (({1'b0, mid_count} + {3'b0, f1_v_ff} + {3'b0, f2_v_ff})
                     >= 4'(swb_pkg::MID_DEPTH));
   assign accept  = in_push && !in_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= accept;
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_req_ff   <= in_type;
      f1_wr_ok_ff <= ({4'b0, in_src_col} < MAX_W) && ({4'b0, in_src_row} < MAX_H);
      f1_col_ff   <= in_src_col;
      f1_row_ff   <= in_src_row;
      f1_pix_ff   <= in_pix;
      f1_dc_ff    <= in_dst_col;
      f1_dr_ff    <= in_dst_row;
      f1_ac_ff    <= cfg.scale_cos * $signed({1'b0, in_dst_col});
      f1_br_ff    <= cfg.scale_sin * $signed({1'b0, in_dst_row});
      f1_bc_ff    <= cfg.scale_sin * $signed({1'b0, in_dst_col});
      f1_ar_ff    <= cfg.scale_cos * $signed({1'b0, in_dst_row});
   end

   always_comb begin
      sc = {{2{f1_ac_ff[39]}}, f1_ac_ff} - {{2{f1_br_ff[39]}}, f1_br_ff}
         + {{10{cfg.shift_col[31]}}, cfg.shift_col};
      sr = {{2{f1_bc_ff[39]}}, f1_bc_ff} + {{2{f1_ar_ff[39]}}, f1_ar_ff}
         + {{10{cfg.shift_row[31]}}, cfg.shift_row};
      w_eff = ({3'b0, cfg.src_width} > MAX_W) ? MAX_W : {3'b0, cfg.src_width};
      h_eff = ({3'b0, cfg.src_height} > MAX_H) ? MAX_H : {3'b0, cfg.src_height};
      inside_in = !sc[41] && !sr[41]
               && (({1'b0, sc[40:16]} + 26'd1) < {13'd0, w_eff})
               && (({1'b0, sr[40:16]} + 26'd1) < {13'd0, h_eff});
      col_in = f1_req_ff ? sc[16 +: swb_pkg::COORD_W] : {3'b0, f1_col_ff};
      row_in = f1_req_ff ? sr[16 +: swb_pkg::COORD_W] : {3'b0, f1_row_ff};
   end

   always_ff @(posedge clock) begin
      f2_req_ff    <= f1_req_ff;
      f2_wr_ok_ff  <= f1_wr_ok_ff;
      f2_inside_ff <= f1_req_ff && inside_in;
      f2_col_ff    <= col_in;
      f2_row_ff    <= row_in;
      f2_fc_ff     <= sc[15:8];
      f2_fr_ff     <= sr[15:8];
      f2_pix_ff    <= f1_pix_ff;
      f2_dc_ff     <= f1_dc_ff;
      f2_dr_ff     <= f1_dr_ff;
   end

   always_comb begin
      wc  = 9'd256 - {1'b0, f2_fc_ff};
      wr  = 9'd256 - {1'b0, f2_fr_ff};
      p00 = wr * wc;
      p01 = wr * {1'b0, f2_fc_ff};
      p10 = {1'b0, f2_fr_ff} * wc;
      p11 = {1'b0, f2_fr_ff} * {1'b0, f2_fc_ff};
      mid_item.is_req    = f2_req_ff;
      mid_item.wr_ok     = f2_wr_ok_ff;
      mid_item.in_bounds = f2_inside_ff;
      mid_item.col       = f2_col_ff;
      mid_item.row       = f2_row_ff;
      mid_item.pix       = f2_pix_ff;
      mid_item.w00       = p00[16:0];
      mid_item.w01       = p01[16:0];
      mid_item.w10       = p10[16:0];
      mid_item.w11       = p11[16:0];
      mid_item.dst_col   = f2_dc_ff;
      mid_item.dst_row   = f2_dr_ff;
   end

   assign mid_push = f2_v_ff;

endmodule

FILE: rtl/swb_back.sv
// Back: banked pixel store access and bilinear blend.
module swb_back #(
   parameter int MAX_SRC_WIDTH  = 512,
   parameter int MAX_SRC_HEIGHT = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       mid_empty,
   input  swb_pkg::swb_item_type      mid_item,
   output logic                       mid_pop,
   input  logic [swb_pkg::OUT_CW-1:0] out_count,
   output logic                       out_push,
   output swb_pkg::swb_result_type    out_data
);

   localparam int HC_RAW = $clog2((MAX_SRC_WIDTH + 1) / 2);
   localparam int HR_RAW = $clog2((MAX_SRC_HEIGHT + 1) / 2);
   localparam int HC     = (HC_RAW < 1) ? 1 : HC_RAW;
   localparam int HR     = (HR_RAW < 1) ? 1 : HR_RAW;
   localparam int BANK_AW    = HC + HR;
   localparam int BANK_DEPTH = 1 << BANK_AW;

   logic [12:0]        colp [2];
   logic [12:0]        rowp [2];
   logic [HC-1:0]      chalf [2];
   logic [HR-1:0]      rhalf [2];
   logic [BANK_AW-1:0] wr_addr;
   logic [1:0]         wr_bank;
   logic [23:0]        rd_data [4];

   logic        s1_v_ff, s1_inside_ff, s1_pc_ff, s1_pr_ff;
   logic [16:0] s1_w_ff [4];
   logic [6:0]  s1_dc_ff, s1_dr_ff;

   logic        s2_v_ff, s2_inside_ff;
   logic [24:0] s2_prod_ff [3][4];
   logic [6:0]  s2_dc_ff, s2_dr_ff;

   logic [23:0] pix [4];
   logic [26:0] sum [3];

   // reserve room downstream for everything still in the pipe
   assign mid_pop = !mid_empty
      && (({1'b0, out_count} + {3'b0, s1_v_ff} + {3'b0, s2_v_ff})
          < 4'(swb_pkg::OUT_DEPTH));

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         colp[p]  = (mid_item.col[0] == p[0]) ? {1'b0, mid_item.col}
                                              : {1'b0, mid_item.col} + 13'd1;
         rowp[p]  = (mid_item.row[0] == p[0]) ? {1'b0, mid_item.row}
                                              : {1'b0, mid_item.row} + 13'd1;
         chalf[p] = colp[p][HC:1];
         rhalf[p] = rowp[p][HR:1];
      end
      wr_addr = {mid_item.row[HR:1], mid_item.col[HC:1]};
      wr_bank = {mid_item.row[0], mid_item.col[0]};
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic bank_we;
      assign bank_we = mid_pop && !mid_item.is_req && mid_item.wr_ok && (wr_bank == 2'(b));
      swb_ram #(
         .WIDTH (24),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_we),
         .wr_addr (wr_addr),
         .wr_data (mid_item.pix),
         .rd_addr ({rhalf[b / 2], chalf[b % 2]}),
         .rd_data (rd_data[b])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= mid_pop && mid_item.is_req;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_inside_ff <= mid_item.in_bounds;
      s1_pc_ff     <= mid_item.col[0];
      s1_pr_ff     <= mid_item.row[0];
      s1_w_ff[0]   <= mid_item.w00;
      s1_w_ff[1]   <= mid_item.w01;
      s1_w_ff[2]   <= mid_item.w10;
      s1_w_ff[3]   <= mid_item.w11;
      s1_dc_ff     <= mid_item.dst_col;
      s1_dr_ff     <= mid_item.dst_row;
   end

   // route banks back to the neighbor positions
   always_comb begin
      pix[0] = rd_data[{s1_pr_ff, s1_pc_ff}];
      pix[1] = rd_data[{s1_pr_ff, !s1_pc_ff}];
      pix[2] = rd_data[{!s1_pr_ff, s1_pc_ff}];
      pix[3] = rd_data[{!s1_pr_ff, !s1_pc_ff}];
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 4; k++) begin
            s2_prod_ff[ch][k] <= s1_w_ff[k] * pix[k][ch*8 +: 8];
         end
      end
      s2_inside_ff <= s1_inside_ff;
      s2_dc_ff     <= s1_dc_ff;
      s2_dr_ff     <= s1_dr_ff;
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = {2'b0, s2_prod_ff[ch][0]} + {2'b0, s2_prod_ff[ch][1]}
                 + {2'b0, s2_prod_ff[ch][2]} + {2'b0, s2_prod_ff[ch][3]};
      end
      out_data.red       = s2_inside_ff ? sum[0][23:16] : 8'd0;
      out_data.green     = s2_inside_ff ? sum[1][23:16] : 8'd0;
      out_data.blue      = s2_inside_ff ? sum[2][23:16] : 8'd0;
      out_data.in_bounds = s2_inside_ff;
      out_data.col       = s2_dc_ff;
      out_data.row       = s2_dr_ff;
   end

   assign out_push = s2_v_ff;

endmodule

FILE: rtl/similarity_warp_bilinear_core.sv
// Top level of the similarity warp core with bilinear resampling.
//
// Takes one item per cycle while full is low, pixel write or warp
// request, and returns one result per request at one per cycle while the
// result queue has room. The front maps the request through the Q16.16
// similarity transform in two stages, a four-entry queue parts it from
// the back, which reads the four neighbors at once from a store split
// into four banks by row and column parity, weights them in the next
// stage and sums them into a four-entry result queue. The pixel store
// needs no clearing pass; reading a never-written pixel gives an
// unspecified value.
module similarity_warp_bilinear_core #(
   parameter int MAX_SRC_WIDTH  = 512,
   parameter int MAX_SRC_HEIGHT = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_type,
   input  logic [8:0]  req_src_col,
   input  logic [8:0]  req_src_row,
   input  logic [7:0]  req_pixel_red,
   input  logic [7:0]  req_pixel_green,
   input  logic [7:0]  req_pixel_blue,
   input  logic [6:0]  req_dst_col,
   input  logic [6:0]  req_dst_row,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_inside_res,
   output logic [6:0]  rsp_out_col,
   output logic [6:0]  rsp_out_row,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   swb_pkg::swb_cfg_type    cfg_ff;
   swb_pkg::swb_item_type   mid_in, mid_out;
   swb_pkg::swb_result_type out_in, out_out;
   logic                       mid_push, mid_pop, mid_empty;
   logic [swb_pkg::MID_CW-1:0] mid_count;
   logic                       out_push, out_empty;
   logic [swb_pkg::OUT_CW-1:0] out_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_cos  <= 32'sd65536;
         cfg_ff.scale_sin  <= '0;
         cfg_ff.shift_col  <= '0;
         cfg_ff.shift_row  <= '0;
         cfg_ff.src_width  <= 10'd512;
         cfg_ff.src_height <= 10'd512;
      end else if (csr_we) begin
         unique case (csr_addr)
            swb_pkg::CSR_SCALE_COS:  cfg_ff.scale_cos  <= csr_wdata;
            swb_pkg::CSR_SCALE_SIN:  cfg_ff.scale_sin  <= csr_wdata;
            swb_pkg::CSR_SHIFT_COL:  cfg_ff.shift_col  <= csr_wdata;
            swb_pkg::CSR_SHIFT_ROW:  cfg_ff.shift_row  <= csr_wdata;
            swb_pkg::CSR_SRC_WIDTH:  cfg_ff.src_width  <= csr_wdata[9:0];
            swb_pkg::CSR_SRC_HEIGHT: cfg_ff.src_height <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   swb_front #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_push    (push),
      .in_full    (full),
      .in_type    (req_type),
      .in_src_col (req_src_col),
      .in_src_row (req_src_row),
      .in_pix     ({req_pixel_blue, req_pixel_green, req_pixel_red}),
      .in_dst_col (req_dst_col),
      .in_dst_row (req_dst_row),
      .mid_count  (mid_count),
      .mid_push   (mid_push),
      .mid_item   (mid_in)
   );

   swb_fifo #(
      .WIDTH ($bits(swb_pkg::swb_item_type)),
      .DEPTH (swb_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in),
      .pop       (mid_pop),
      .pop_data  (mid_out),
      .empty     (mid_empty),
      .count     (mid_count)
   );

   swb_back #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mid_out),
      .mid_pop   (mid_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_in)
   );

   swb_fifo #(
      .WIDTH ($bits(swb_pkg::swb_result_type)),
      .DEPTH (swb_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_in),
      .pop       (pop),
      .pop_data  (out_out),
      .empty     (out_empty),
      .count     (out_count)
   );

   assign empty          = out_empty;
   assign rsp_out_red    = out_out.red;
   assign rsp_out_green  = out_out.green;
   assign rsp_out_blue   = out_out.blue;
   assign rsp_inside_res = out_out.in_bounds;
   assign rsp_out_col    = out_out.col;
   assign rsp_out_row    = out_out.row;

   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> (mid_count < swb_pkg::MID_CW'(swb_pkg::MID_DEPTH)))
      else $error("mid queue overflow");

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_count < swb_pkg::OUT_CW'(swb_pkg::OUT_DEPTH)))
      else $error("result queue overflow");

   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty)
      else $error("back issued from an empty queue");

endmodule
